>>> sv/slcd_pkg.sv
package slcd_pkg;

  localparam int NIBBLE_COUNT = 10;
  localparam int NIBBLE_W     = 4;
  localparam int INDEX_W      = 4;
  localparam int CODE_W       = 8;
  localparam int CMD_W        = 2;
  localparam int NIB_IDX_W    = (NIBBLE_COUNT > 1) ? $clog2(NIBBLE_COUNT) : 1;

  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 8;

  localparam logic [CMD_W-1:0] CMD_CODE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FILL  = 2'd3;

  localparam int HEAD_W   = 12;
  localparam int HCNT_W   = 4;
  localparam logic [2:0] MODE_CMD  = 3'b100;
  localparam logic [2:0] MODE_DATA = 3'b101;
  localparam logic [HCNT_W-1:0] CODE_FRAME_BITS = 4'd12;
  localparam logic [HCNT_W-1:0] DATA_HEAD_BITS  = 4'd9;

endpackage

>>> sv/slcd_nibble_store.sv
module slcd_nibble_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [slcd_pkg::INDEX_W-1:0]  wr_index,
  input  logic [slcd_pkg::NIBBLE_W-1:0] wr_value,
  input  logic [slcd_pkg::NIBBLE_W-1:0] wr_mask,
  input  logic [slcd_pkg::NIB_IDX_W-1:0] rd_index,
  output logic [slcd_pkg::NIBBLE_W-1:0] rd_data
);
  import slcd_pkg::*;

  logic [NIBBLE_W-1:0] nibbles [NIBBLE_COUNT];
  logic                wr_hit;
  logic                rd_hit;

  assign wr_hit = wr_en && (wr_index < INDEX_W'(NIBBLE_COUNT));
  assign rd_hit = {1'b0, rd_index} < (NIB_IDX_W + 1)'(NIBBLE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NIBBLE_COUNT; i++) begin
        nibbles[i] <= '0;
      end
    end else if (wr_hit) begin
      nibbles[wr_index[NIB_IDX_W-1:0]] <=
        (nibbles[wr_index[NIB_IDX_W-1:0]] & ~wr_mask) | (wr_value & wr_mask);
    end
  end

  assign rd_data = rd_hit ? nibbles[rd_index] : '0;

endmodule

>>> sv/segment_lcd_serial_frame_writer.sv
// The first bit of a frame is registered in the header state entered on accept; a sink
// stall can hold it. One serial bit per cycle from a single output register while the
// sink is ready; a flush or fill sends 49 bits, a controller code 12, a nibble write none.
// The bit sequencer handles one command at a time.
// Reset (rst, synchronous) clears the sequencer, the output valid flag and all nibbles.
module segment_lcd_serial_frame_writer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // command_code[7:0], index[11:8], nibble_value[15:12], nibble_mask[19:16], zero fill
  input  logic [slcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [slcd_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // serial_bit[0], zero fill
  output logic [slcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // frame_last
  output logic                             m_axis_tlast
);
  import slcd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0]           state;
  logic [HEAD_W-1:0]    head_sr;
  logic [HCNT_W-1:0]    head_cnt;
  logic                 data_frame;
  logic                 fill;
  logic [NIBBLE_W-1:0]  fill_value;
  logic [NIBBLE_W-1:0]  nib_sr;
  logic [1:0]           bit_cnt;
  logic [NIB_IDX_W-1:0] nib_idx;
  logic                 out_valid;
  logic                 out_bit;
  logic                 out_last;

  logic                 in_take;
  logic                 advance;
  logic [CMD_W-1:0]     command;
  logic [CODE_W-1:0]    command_code;
  logic [INDEX_W-1:0]   index;
  logic [NIBBLE_W-1:0]  nibble_value;
  logic [NIBBLE_W-1:0]  nibble_mask;
  logic [NIB_IDX_W-1:0] rd_index;
  logic [NIBBLE_W-1:0]  rd_data;
  logic [NIBBLE_W-1:0]  next_nibble;

  assign command      = s_axis_tuser;
  assign command_code = s_axis_tdata[7:0];
  assign index        = s_axis_tdata[11:8];
  assign nibble_value = s_axis_tdata[15:12];
  assign nibble_mask  = s_axis_tdata[19:16];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign advance       = (state != ST_IDLE) && (!out_valid || m_axis_tready);

  assign rd_index    = (state == ST_HEAD) ? '0 : nib_idx + NIB_IDX_W'(1);
  assign next_nibble = fill ? fill_value : rd_data;

  slcd_nibble_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_take && (command == CMD_WRITE)),
    .wr_index (index),
    .wr_value (nibble_value),
    .wr_mask  (nibble_mask),
    .rd_index (rd_index),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      head_cnt  <= '0;
      bit_cnt   <= '0;
      nib_idx   <= '0;
    end else begin
      if (out_valid && m_axis_tready && !advance) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            fill       <= (command == CMD_FILL);
            fill_value <= nibble_value;
            case (command)
              CMD_CODE: begin
                head_sr    <= {MODE_CMD, command_code, 1'b0};
                head_cnt   <= CODE_FRAME_BITS;
                data_frame <= 1'b0;
                state      <= ST_HEAD;
              end
              CMD_FLUSH, CMD_FILL: begin
                head_sr    <= {MODE_DATA, 9'b0};
                head_cnt   <= DATA_HEAD_BITS;
                data_frame <= 1'b1;
                state      <= ST_HEAD;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_HEAD: begin
          if (advance) begin
            out_valid <= 1'b1;
            out_bit   <= head_sr[HEAD_W-1];
            head_sr   <= {head_sr[HEAD_W-2:0], 1'b0};
            head_cnt  <= head_cnt - HCNT_W'(1);
            out_last  <= (head_cnt == HCNT_W'(1)) && !data_frame;
            if (head_cnt == HCNT_W'(1)) begin
              if (data_frame) begin
                nib_idx <= '0;
                bit_cnt <= '0;
                nib_sr  <= next_nibble;
                state   <= ST_DATA;
              end else begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_DATA: begin
          if (advance) begin
            out_valid <= 1'b1;
            out_bit   <= nib_sr[0];
            bit_cnt   <= bit_cnt + 2'd1;
            out_last  <= (bit_cnt == 2'd3) && (nib_idx == NIB_IDX_W'(NIBBLE_COUNT - 1));
            if (bit_cnt == 2'd3) begin
              if (nib_idx == NIB_IDX_W'(NIBBLE_COUNT - 1)) begin
                state  <= ST_IDLE;
                nib_sr <= {1'b0, nib_sr[NIBBLE_W-1:1]};
              end else begin
                nib_idx <= nib_idx + NIB_IDX_W'(1);
                nib_sr  <= next_nibble;
              end
            end else begin
              nib_sr <= {1'b0, nib_sr[NIBBLE_W-1:1]};
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, out_bit};
  assign m_axis_tlast  = out_last;

`ifndef SYNTH
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD) |-> (head_cnt != '0))
    else $error("header phase with no bits left");

  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (in_take && (command == CMD_FLUSH || command == CMD_FILL))
      |=> (state == ST_HEAD && head_cnt == DATA_HEAD_BITS && data_frame))
    else $error("data frame did not start with its header");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (in_take && command == CMD_WRITE) |=> (state == ST_IDLE))
    else $error("nibble write left the idle state");

  a_nib_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DATA) |-> ({1'b0, nib_idx} < (NIB_IDX_W + 1)'(NIBBLE_COUNT)))
    else $error("nibble index beyond buffer");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (state != ST_DATA))
    else $error("frame end marked while data still being sent");
`endif

endmodule

>>> test/segment_lcd_frame_checker.sv
module segment_lcd_frame_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [slcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [slcd_pkg::CMD_W-1:0]       s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [slcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             m_axis_tlast,
  output int                               mismatches,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import slcd_pkg::*;

  typedef struct packed {
    logic serial_bit;
    logic frame_last;
  } lcd_bit_t;

  lcd_bit_t            bits_due[$];
  logic [NIBBLE_W-1:0] shadow_nibbles [NIBBLE_COUNT];
  int                  fail_count = 0;

  assign mismatches  = fail_count;
  assign outstanding = bits_due.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void push_bit(input logic b, input logic last);
    lcd_bit_t e;
    e.serial_bit = b;
    e.frame_last = last;
    bits_due.push_back(e);
  endfunction

  task automatic predict_frame(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                               input logic [INDEX_W-1:0] idx, input logic [NIBBLE_W-1:0] val,
                               input logic [NIBBLE_W-1:0] mask);
    logic [NIBBLE_W-1:0] nib;
    int i;
    int n;
    case (cmd)
      CMD_CODE: begin
        for (i = 2; i >= 0; i--) push_bit(MODE_CMD[i], 1'b0);
        for (i = CODE_W - 1; i >= 0; i--) push_bit(code[i], 1'b0);
        push_bit(1'b0, 1'b1);
      end
      CMD_WRITE: begin
        if (idx < NIBBLE_COUNT)
          shadow_nibbles[idx] = (shadow_nibbles[idx] & ~mask) | (val & mask);
      end
      default: begin
        for (i = 2; i >= 0; i--) push_bit(MODE_DATA[i], 1'b0);
        for (i = 0; i < 6; i++) push_bit(1'b0, 1'b0);
        for (n = 0; n < NIBBLE_COUNT; n++) begin
          nib = (cmd == CMD_FILL) ? val : shadow_nibbles[n];
          for (i = 0; i < NIBBLE_W; i++)
            push_bit(nib[i], (n == NIBBLE_COUNT - 1) && (i == NIBBLE_W - 1));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    lcd_bit_t want;
    if (rst) begin
      bits_due.delete();
      for (int k = 0; k < NIBBLE_COUNT; k++) shadow_nibbles[k] = '0;
    end else begin
      // new frame goes to the back, so predicting first is safe
      if (s_axis_tvalid && s_axis_tready)
        predict_frame(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[11:8],
                      s_axis_tdata[15:12], s_axis_tdata[19:16]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (bits_due.size() == 0) begin
          report("unexpected transaction, serial_bit", int'(m_axis_tdata[0]), -1);
        end else begin
          want = bits_due.pop_front();
          if (m_axis_tdata[0] !== want.serial_bit)
            report("serial_bit", int'(m_axis_tdata[0]), int'(want.serial_bit));
          if (m_axis_tlast !== want.frame_last)
            report("frame_last", int'(m_axis_tlast), int'(want.frame_last));
        end
      end
    end
  end

endmodule

>>> test/tb_segment_lcd_serial_frame_writer.sv
module tb_segment_lcd_serial_frame_writer;
  timeunit 1ns;
  timeprecision 1ps;
  import slcd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 320;
  localparam int TAIL_CYCLES  = 60;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = CMD_CODE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always #10 clk = ~clk;

  segment_lcd_serial_frame_writer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  segment_lcd_frame_checker u_frame_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                           input logic [INDEX_W-1:0] idx, input logic [NIBBLE_W-1:0] val,
                           input logic [NIBBLE_W-1:0] mask);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, mask, val, idx, code};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // sampled on the falling edge so the checker has settled
  task automatic wait_frames_done();
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin : sink
    int stall;
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(24, 1)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0]    cmd;
    logic [CODE_W-1:0]   code;
    logic [INDEX_W-1:0]  idx;
    logic [NIBBLE_W-1:0] val;
    logic [NIBBLE_W-1:0] mask;
    int  roll;
    int  counted;
    bit  paused;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: buffer clear after reset, code extremes, masks, range edge, fills
    send_item(CMD_FLUSH, CODE_W'($urandom), INDEX_W'($urandom), NIBBLE_W'($urandom),
              NIBBLE_W'($urandom));
    send_item(CMD_CODE, 8'h00, 4'h0, 4'h0, 4'h0);
    send_item(CMD_CODE, 8'hFF, 4'hF, 4'hF, 4'hF);
    send_item(CMD_CODE, 8'hA5, INDEX_W'($urandom), NIBBLE_W'($urandom), NIBBLE_W'($urandom));
    send_item(CMD_WRITE, CODE_W'($urandom), 4'd0, 4'hF, 4'hF);
    send_item(CMD_WRITE, CODE_W'($urandom), INDEX_W'(NIBBLE_COUNT - 1), 4'hF, 4'hF);
    send_item(CMD_WRITE, CODE_W'($urandom), INDEX_W'(NIBBLE_COUNT), 4'hF, 4'hF);
    send_item(CMD_WRITE, CODE_W'($urandom), 4'hF, 4'hF, 4'hF);
    send_item(CMD_WRITE, CODE_W'($urandom), 4'd4, 4'hF, 4'h0);
    send_item(CMD_WRITE, CODE_W'($urandom), 4'd4, 4'hA, 4'h6);
    send_item(CMD_WRITE, CODE_W'($urandom), 4'd2, 4'h5, 4'hF);
    send_item(CMD_FLUSH, CODE_W'($urandom), INDEX_W'($urandom), NIBBLE_W'($urandom),
              NIBBLE_W'($urandom));
    quiet = 1'b1;
    send_item(CMD_WRITE, CODE_W'($urandom), 4'd0, 4'h0, 4'h9);
    send_item(CMD_FLUSH, CODE_W'($urandom), INDEX_W'($urandom), NIBBLE_W'($urandom),
              NIBBLE_W'($urandom));
    send_item(CMD_FILL, CODE_W'($urandom), INDEX_W'($urandom), 4'h0, NIBBLE_W'($urandom));
    send_item(CMD_FILL, CODE_W'($urandom), INDEX_W'($urandom), 4'hF, NIBBLE_W'($urandom));
    send_item(CMD_FILL, CODE_W'($urandom), INDEX_W'($urandom), 4'h6, NIBBLE_W'($urandom));
    quiet = 1'b0;
    send_item(CMD_FLUSH, CODE_W'($urandom), INDEX_W'($urandom), NIBBLE_W'($urandom),
              NIBBLE_W'($urandom));
    send_item(CMD_CODE, 8'h5A, INDEX_W'($urandom), NIBBLE_W'($urandom), NIBBLE_W'($urandom));

    counted = 0;
    paused  = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(49) == 0) quiet = !quiet;
      if (!paused && counted >= RANDOM_ITEMS / 2) begin
        s_axis_tvalid <= 1'b0;
        wait_frames_done();
        paused = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 40)      cmd = CMD_WRITE;
      else if (roll < 60) cmd = CMD_CODE;
      else if (roll < 82) cmd = CMD_FLUSH;
      else                cmd = CMD_FILL;
      code = CODE_W'($urandom);
      val  = NIBBLE_W'($urandom);
      mask = NIBBLE_W'($urandom);
      if ($urandom_range(9) == 0) idx = INDEX_W'($urandom_range(15, NIBBLE_COUNT));
      else                        idx = INDEX_W'($urandom_range(NIBBLE_COUNT - 1, 0));
      send_item(cmd, code, idx, val, mask);
      if (!(cmd == CMD_WRITE && idx >= NIBBLE_COUNT)) counted++;
    end
    s_axis_tvalid <= 1'b0;

    wait_frames_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
